// File: hw/rtl/gwwb_pkg.sv
// gray-world white balance: shared types and codes
// used by the controller, the datapath and the checker; no dependencies
package gwwb_pkg;

  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_ACCUM   = 2'd1,
    FUNC_GAIN    = 2'd2,
    FUNC_CORRECT = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_INIT,
    ST_STEP,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic  clr;
    logic  acc;
    logic  corr;
    logic  ld_total;
    logic  setup;
    logic  init;
    logic  step;
    logic  wr_gain;
    chan_e chan;
  } cmd_t;

endpackage

// File: hw/rtl/gwwb_ctrl.sv
// gray-world white balance: controller state machine
// sequences the gain division over the three channels; uses gwwb_pkg
module gwwb_ctrl #(
  parameter int GAIN_BITS = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  gwwb_pkg::func_e func_i,
  input  logic            skid_full_i,
  output logic            in_stall_o,
  output gwwb_pkg::cmd_t  cmd_o
);
  import gwwb_pkg::*;

  localparam int CNT_W = $clog2(GAIN_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_BITS - 1);

  state_e           state_q, state_d;
  chan_e            chan_q, chan_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             fire;

  assign in_stall_o = (state_q != ST_IDLE) | skid_full_i;
  assign fire       = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chan_q  <= CH_RED;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      chan_q  <= chan_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    chan_d  = chan_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.chan = chan_q;
    unique case (state_q)
      ST_IDLE: begin
        if (fire) begin
          unique case (func_i)
            FUNC_CLEAR:   cmd_o.clr  = 1'b1;
            FUNC_ACCUM:   cmd_o.acc  = 1'b1;
            FUNC_CORRECT: cmd_o.corr = 1'b1;
            FUNC_GAIN: begin
              cmd_o.ld_total = 1'b1;
              chan_d         = CH_RED;
              state_d        = ST_SETUP;
            end
            default: ;
          endcase
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        cnt_d      = '0;
        state_d    = ST_STEP;
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = ST_WRITE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_WRITE: begin
        cmd_o.wr_gain = 1'b1;
        unique case (chan_q)
          CH_RED: begin
            chan_d  = CH_GREEN;
            state_d = ST_SETUP;
          end
          CH_GREEN: begin
            chan_d  = CH_BLUE;
            state_d = ST_SETUP;
          end
          default: begin
            chan_d  = CH_RED;
            state_d = ST_IDLE;
          end
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/gwwb_dp.sv
// gray-world white balance: datapath with sums, gain divider and output stage
// driven by gwwb_ctrl through gwwb_pkg::cmd_t
module gwwb_dp #(
  parameter int PIXEL_COUNT_BITS = 21,
  parameter int GAIN_FRAC_BITS   = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gwwb_pkg::cmd_t cmd_i,
  input  logic [7:0]     in_red_i,
  input  logic [7:0]     in_green_i,
  input  logic [7:0]     in_blue_i,
  input  logic           out_stall_i,
  output logic           skid_full_o,
  output logic           out_valid_o,
  output logic [7:0]     out_red_o,
  output logic [7:0]     out_green_o,
  output logic [7:0]     out_blue_o
);
  import gwwb_pkg::*;

  localparam int SUM_BITS  = PIXEL_COUNT_BITS + 8;
  localparam int SUM_W1    = SUM_BITS + 1;
  localparam int GAIN_BITS = GAIN_FRAC_BITS + 8;
  localparam int PROD_W    = GAIN_BITS + 8;
  localparam int D_W       = SUM_BITS + 2;
  localparam logic [SUM_BITS-1:0]  SUM_MAX  = '1;
  localparam logic [GAIN_BITS-1:0] GAIN_MAX = '1;

  function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] s,
                                                  input logic [7:0] p);
    logic [SUM_BITS:0] t;
    t = {1'b0, s} + SUM_W1'(p);
    return t[SUM_BITS] ? SUM_MAX : t[SUM_BITS-1:0];
  endfunction

  function automatic logic [7:0] apply_gain(input logic [7:0] p,
                                            input logic [GAIN_BITS-1:0] g);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(p) * PROD_W'(g);
    return (|prod[PROD_W-1:GAIN_FRAC_BITS+8]) ? 8'hff
                                               : prod[GAIN_FRAC_BITS+7:GAIN_FRAC_BITS];
  endfunction

  logic [SUM_BITS-1:0]  red_sum_q, green_sum_q, blue_sum_q;
  logic [GAIN_BITS-1:0] red_gain_q, green_gain_q, blue_gain_q;
  logic [D_W-1:0]       total_q, div_q, rem_q;
  logic [GAIN_BITS-1:0] quot_q, nlow_q, gain_val;
  logic                 zero_q, ovf_q;
  logic [SUM_BITS-1:0]  ch_sum;
  logic [D_W-1:0]       total_hi;
  logic [D_W:0]         trial;
  logic                 ge;
  logic [7:0]           res_r, res_g, res_b;
  logic                 out_valid_q, skid_valid_q;
  logic [7:0]           out_r_q, out_g_q, out_b_q;
  logic [7:0]           skid_r_q, skid_g_q, skid_b_q;

  always_comb begin
    case (cmd_i.chan)
      CH_RED:   ch_sum = red_sum_q;
      CH_GREEN: ch_sum = green_sum_q;
      default:  ch_sum = blue_sum_q;
    endcase
  end

  assign total_hi = D_W'(total_q >> 8);
  assign trial    = {rem_q, nlow_q[GAIN_BITS-1]};
  assign ge       = trial >= {1'b0, div_q};
  assign gain_val = zero_q ? '0 : (ovf_q ? GAIN_MAX : quot_q);

  // channel sums and gains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_sum_q    <= '0;
      green_sum_q  <= '0;
      blue_sum_q   <= '0;
      red_gain_q   <= '0;
      green_gain_q <= '0;
      blue_gain_q  <= '0;
    end else begin
      if (cmd_i.clr) begin
        red_sum_q   <= '0;
        green_sum_q <= '0;
        blue_sum_q  <= '0;
      end else if (cmd_i.acc) begin
        red_sum_q   <= sat_add(red_sum_q, in_red_i);
        green_sum_q <= sat_add(green_sum_q, in_green_i);
        blue_sum_q  <= sat_add(blue_sum_q, in_blue_i);
      end
      if (cmd_i.wr_gain) begin
        case (cmd_i.chan)
          CH_RED:   red_gain_q   <= gain_val;
          CH_GREEN: green_gain_q <= gain_val;
          default:  blue_gain_q  <= gain_val;
        endcase
      end
    end
  end

  // restoring divider, one quotient bit per step
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_total) begin
      total_q <= D_W'(red_sum_q) + D_W'(green_sum_q) + D_W'(blue_sum_q);
    end
    if (cmd_i.setup) begin
      div_q  <= D_W'(ch_sum) + (D_W'(ch_sum) << 1);
      zero_q <= (ch_sum == '0);
    end
    if (cmd_i.init) begin
      rem_q  <= total_hi;
      ovf_q  <= (total_hi >= div_q);
      quot_q <= '0;
      nlow_q <= GAIN_BITS'(total_q[7:0]) << GAIN_FRAC_BITS;
    end else if (cmd_i.step) begin
      rem_q  <= ge ? D_W'(trial - {1'b0, div_q}) : trial[D_W-1:0];
      quot_q <= {quot_q[GAIN_BITS-2:0], ge};
      nlow_q <= nlow_q << 1;
    end
  end

  assign res_r = apply_gain(in_red_i, red_gain_q);
  assign res_g = apply_gain(in_green_i, green_gain_q);
  assign res_b = apply_gain(in_blue_i, blue_gain_q);

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q  <= skid_valid_q | cmd_i.corr;
      skid_valid_q <= 1'b0;
    end else if (cmd_i.corr) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_r_q <= skid_r_q;
        out_g_q <= skid_g_q;
        out_b_q <= skid_b_q;
      end else if (cmd_i.corr) begin
        out_r_q <= res_r;
        out_g_q <= res_g;
        out_b_q <= res_b;
      end
    end else if (cmd_i.corr) begin
      skid_r_q <= res_r;
      skid_g_q <= res_g;
      skid_b_q <= res_b;
    end
  end

  assign skid_full_o = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_r_q;
  assign out_green_o = out_g_q;
  assign out_blue_o  = out_b_q;

endmodule

// File: hw/rtl/gray_world_white_balance_core.sv
// Gray-world white balance over a pixel stream in two passes. Clear,
// accumulate and correct transactions are taken one per cycle unless the
// input is stalled; a correct transaction's balanced pixel goes to the
// output register, or to the skid stage while the output is stalled: the
// output register plus the skid stage let one more transaction in while a
// result waits. A compute-gains transaction holds off the input until the
// gains of all three channels are written; the restoring divider yields
// one gain bit per cycle and serves the three channels in turn. Gains are
// Q8.GAIN_FRAC_BITS, saturated, and zero for a channel whose sum is zero.
// top level: instantiates gwwb_ctrl and gwwb_dp, uses gwwb_pkg
module gray_world_white_balance_core #(
  parameter int PIXEL_COUNT_BITS = 21,
  parameter int GAIN_FRAC_BITS   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] func_i,
  input  logic [7:0] in_red_i,
  input  logic [7:0] in_green_i,
  input  logic [7:0] in_blue_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o
);
  import gwwb_pkg::*;

  cmd_t cmd;
  logic skid_full;

  gwwb_ctrl #(
    .GAIN_BITS (GAIN_FRAC_BITS + 8)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (func_e'(func_i)),
    .skid_full_i (skid_full),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  gwwb_dp #(
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS),
    .GAIN_FRAC_BITS   (GAIN_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .out_stall_i (out_stall_i),
    .skid_full_o (skid_full),
    .out_valid_o (out_valid_o),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o)
  );

endmodule

// File: hw/rtl/gwwb_checker.sv
// gray-world white balance: port-level checker and its bind to the top level
// uses gwwb_pkg for the function codes
module gwwb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] func_i,
  input logic [7:0] in_red_i,
  input logic [7:0] in_green_i,
  input logic [7:0] in_blue_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_red_o,
  input logic [7:0] out_green_o,
  input logic [7:0] out_blue_o
);
  import gwwb_pkg::*;

  logic in_fire;
  assign in_fire = in_valid_i & ~in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(out_red_o) && $stable(out_green_o) && $stable(out_blue_o))
    else $error("stalled output payload changed");

  a_gain_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && func_i == FUNC_GAIN |=> in_stall_o)
    else $error("input not held off during gain computation");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_fire && func_i == FUNC_CORRECT))
    else $error("output appeared without a correct transaction");

endmodule

bind gray_world_white_balance_core gwwb_checker u_gwwb_checker (.*);
